### hdl/slsaf_pkg.sv
// shared types for the square level set area fraction pipeline
`default_nettype none
package slsaf_pkg;

  typedef enum logic [2:0] {
    MODE_EMPTY,
    MODE_FULL,
    MODE_TRI_IN,
    MODE_TRI_OUT,
    MODE_TRAP,
    MODE_DIAG_SPLIT,
    MODE_DIAG_JOIN
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] rot;
  } ctl_t;

endpackage
`default_nettype wire

### hdl/slsaf_front.sv
// corner classification, rotation choice and divider operand setup
`default_nettype none
module slsaf_front #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0][W-1:0]     ring,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0][W-1:0]     num,
  output logic [3:0][W-1:0]     den,
  output slsaf_pkg::ctl_t       ctl
);
  import slsaf_pkg::*;

  logic                 v_r;
  logic                 en;
  logic [3:0][W-1:0]    num_r, num_nxt;
  logic [3:0][W-1:0]    den_r, den_nxt;
  ctl_t                 ctl_r, ctl_nxt;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [3:0]         ins;
    logic [2:0]         cnt;
    logic [1:0]         rot;
    logic               found;
    logic               ok;
    logic signed [W+1:0] centre;
    logic signed [W:0]  neg_ext;
    logic [W:0]         sum;
    logic [W-1:0]       mag;
    logic [W-1:0]       other;
    logic [1:0]         nb;
    logic [1:0]         r2;
    logic [1:0]         rr;
    ins     = '0;
    cnt     = '0;
    centre  = '0;
    neg_ext = '0;
    sum     = '0;
    mag     = '0;
    other   = '0;
    for (int k = 0; k < 4; k++) begin
      ins[k] = ring[k][W-1];
      cnt    = cnt + {2'b00, ring[k][W-1]};
      centre = centre + {{2{ring[k][W-1]}}, ring[k]};
    end
    rot   = '0;
    found = 1'b0;
    for (int r = 0; r < 4; r++) begin
      rr = 2'(r);
      nb = rr + 2'd1;
      r2 = rr + 2'd2;
      case (cnt)
        3'd3:    ok = !ins[rr];
        3'd1:    ok = ins[rr];
        default: ok = ins[rr] && (ins[nb] || ins[r2]);
      endcase
      if (ok && !found) begin
        rot   = rr;
        found = 1'b1;
      end
    end
    // one divider lane per ring edge k to k+1
    for (int k = 0; k < 4; k++) begin
      nb = 2'(k) + 2'd1;
      if (ins[k] && ins[nb]) begin
        num_nxt[k] = W'(1);
        den_nxt[k] = W'(1);
      end else if (!ins[k] && !ins[nb]) begin
        num_nxt[k] = '0;
        den_nxt[k] = W'(1);
      end else begin
        neg_ext    = ins[k] ? -{ring[k][W-1], ring[k]} : -{ring[nb][W-1], ring[nb]};
        mag        = neg_ext[W-1:0];
        other      = ins[k] ? ring[nb] : ring[k];
        sum        = {1'b0, mag} + {1'b0, other};
        num_nxt[k] = mag;
        den_nxt[k] = sum[W-1:0];
      end
    end
    ctl_nxt.rot = rot;
    nb = rot + 2'd1;
    case (cnt)
      3'd0:    ctl_nxt.mode = MODE_EMPTY;
      3'd1:    ctl_nxt.mode = MODE_TRI_IN;
      3'd2: begin
        if (ins[nb])             ctl_nxt.mode = MODE_TRAP;
        else if (centre[W+1])    ctl_nxt.mode = MODE_DIAG_SPLIT;
        else                     ctl_nxt.mode = MODE_DIAG_JOIN;
      end
      3'd3:    ctl_nxt.mode = MODE_TRI_OUT;
      default: ctl_nxt.mode = MODE_FULL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = v_r;
  assign num       = num_r;
  assign den       = den_r;
  assign ctl       = ctl_r;

endmodule
`default_nettype wire

### hdl/slsaf_divider.sv
// four-lane restoring divider, one quotient bit per stage
`default_nettype none
module slsaf_divider #(
  parameter int W = 16,
  parameter int F = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0][W-1:0]     num,
  input  logic [3:0][W-1:0]     den,
  input  slsaf_pkg::ctl_t       in_ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0][F:0]       frac,
  output slsaf_pkg::ctl_t       out_ctl
);
  import slsaf_pkg::*;

  localparam int S = F + 1;

  logic [S-1:0]            v_r;
  logic [S-1:0]            en;
  logic [3:0][W-1:0]       rem_r [S];
  logic [3:0][W-1:0]       den_r [S];
  logic [3:0][F:0]         q_r   [S];
  ctl_t                    ctl_r [S];

  always_comb begin
    en[S-1] = !v_r[S-1] || out_ready;
    for (int k = S - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [3:0][W-1:0] rem_nxt;
    logic [3:0][F:0]   q_nxt;
    logic              v_in;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          // integer bit: num never exceeds den
          if (num[l] >= den[l]) begin
            rem_nxt[l] = num[l] - den[l];
            q_nxt[l]   = (F+1)'(1);
          end else begin
            rem_nxt[l] = num[l];
            q_nxt[l]   = '0;
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[k] && v_in) begin
          den_r[k] <= den;
          ctl_r[k] <= in_ctl;
        end
      end
    end else begin : g_next
      assign v_in = v_r[k-1];
      always_comb begin
        logic [W:0] r2;
        logic [W:0] dx;
        logic [W:0] diff;
        for (int l = 0; l < 4; l++) begin
          r2   = {rem_r[k-1][l], 1'b0};
          dx   = {1'b0, den_r[k-1][l]};
          diff = r2 - dx;
          if (r2 >= dx) begin
            rem_nxt[l] = diff[W-1:0];
            q_nxt[l]   = {q_r[k-1][l][F-1:0], 1'b1};
          end else begin
            rem_nxt[l] = r2[W-1:0];
            q_nxt[l]   = {q_r[k-1][l][F-1:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[k] && v_in) begin
          den_r[k] <= den_r[k-1];
          ctl_r[k] <= ctl_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && v_in) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign out_valid = v_r[S-1];
  assign frac      = q_r[S-1];
  assign out_ctl   = ctl_r[S-1];

endmodule
`default_nettype wire

### hdl/slsaf_area.sv
// area assembly: operand select, products, final sum and complement
`default_nettype none
module slsaf_area #(
  parameter int F = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0][F:0]       frac,
  input  slsaf_pkg::ctl_t       ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [F:0]            area
);
  import slsaf_pkg::*;

  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [2:0]      v_r;
  logic [2:0]      en;
  logic [F:0]      a1_r, b1_r, a2_r, b2_r, trap_r;
  logic [F:0]      a1_nxt, b1_nxt, a2_nxt, b2_nxt, trap_nxt;
  mode_t           mode_a_r, mode_b_r;
  logic [2*F+1:0]  m1_r, m2_r;
  logic [F:0]      trap_b_r;
  logic [F:0]      area_r, area_nxt;

  assign en[2]    = !v_r[2] || out_ready;
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_comb begin
    logic [F:0]   e0, e1, e2, e3;
    logic [F+1:0] tsum;
    logic         comp;
    e0   = frac[ctl.rot];
    e1   = frac[ctl.rot + 2'd1];
    e2   = frac[ctl.rot + 2'd2];
    e3   = frac[ctl.rot + 2'd3];
    tsum = {1'b0, e3} + {1'b0, e1};
    comp = (ctl.mode == MODE_TRI_OUT) || (ctl.mode == MODE_DIAG_SPLIT);
    a1_nxt   = comp ? ONE - e3 : e3;
    // outside triangles sit at the two outside corners
    b1_nxt   = (ctl.mode == MODE_DIAG_SPLIT) ? ONE - e2 : (comp ? ONE - e0 : e0);
    trap_nxt = tsum[F+1:1];
    case (ctl.mode)
      MODE_DIAG_SPLIT: begin
        a2_nxt = ONE - e0;
        b2_nxt = ONE - e1;
      end
      MODE_DIAG_JOIN: begin
        a2_nxt = e1;
        b2_nxt = e2;
      end
      default: begin
        a2_nxt = '0;
        b2_nxt = '0;
      end
    endcase
  end

  always_comb begin
    logic [2*F+2:0] s;
    logic [F:0]     tri_sum;
    s       = {1'b0, m1_r} + {1'b0, m2_r};
    tri_sum = s[2*F+1:F+1];
    case (mode_b_r)
      MODE_EMPTY:      area_nxt = '0;
      MODE_FULL:       area_nxt = ONE;
      MODE_TRI_IN:     area_nxt = tri_sum;
      MODE_DIAG_JOIN:  area_nxt = tri_sum;
      MODE_TRI_OUT:    area_nxt = ONE - tri_sum;
      MODE_DIAG_SPLIT: area_nxt = ONE - tri_sum;
      MODE_TRAP:       area_nxt = trap_b_r;
      default:         area_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      a1_r     <= a1_nxt;
      b1_r     <= b1_nxt;
      a2_r     <= a2_nxt;
      b2_r     <= b2_nxt;
      trap_r   <= trap_nxt;
      mode_a_r <= ctl.mode;
    end
    if (en[1] && v_r[0]) begin
      m1_r     <= a1_r * b1_r;
      m2_r     <= a2_r * b2_r;
      trap_b_r <= trap_r;
      mode_b_r <= mode_a_r;
    end
    if (en[2] && v_r[1]) begin
      area_r <= area_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign area      = area_r;

endmodule
`default_nettype wire

### hdl/square_level_set_area_fraction.sv
// path: front register, divider stages, then the area select, product and sum registers
// throughput: one item per cycle while out_ready holds; the divider has one stage per quotient bit
// every stage holds a valid bit, so a stall fills bubbles before it blocks input
// reset: synchronous active-low rst_n clears all valid bits, data is not reset
// top level of the square level set area fraction pipeline
`default_nettype none
module square_level_set_area_fraction #(
  parameter int PHI_WIDTH      = 16,
  parameter int AREA_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [PHI_WIDTH-1:0] in_corner_bottom_left,
  input  logic signed [PHI_WIDTH-1:0] in_corner_bottom_right,
  input  logic signed [PHI_WIDTH-1:0] in_corner_top_left,
  input  logic signed [PHI_WIDTH-1:0] in_corner_top_right,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [AREA_FRAC_BITS:0]     out_inside_area
);
  import slsaf_pkg::*;

  localparam int W = PHI_WIDTH;
  localparam int F = AREA_FRAC_BITS;

  logic [3:0][W-1:0] ring;
  logic              fr_valid, fr_ready;
  logic [3:0][W-1:0] num, den;
  ctl_t              fr_ctl;
  logic              dv_valid, dv_ready;
  logic [3:0][F:0]   frac;
  ctl_t              dv_ctl;

  // ring order around the square
  assign ring[0] = in_corner_bottom_left;
  assign ring[1] = in_corner_bottom_right;
  assign ring[2] = in_corner_top_right;
  assign ring[3] = in_corner_top_left;

  slsaf_front #(.W(W)) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .ring,
    .out_valid(fr_valid), .out_ready(fr_ready),
    .num, .den, .ctl(fr_ctl)
  );

  slsaf_divider #(.W(W), .F(F)) u_div (
    .clk, .rst_n,
    .in_valid(fr_valid), .in_ready(fr_ready),
    .num, .den, .in_ctl(fr_ctl),
    .out_valid(dv_valid), .out_ready(dv_ready),
    .frac, .out_ctl(dv_ctl)
  );

  slsaf_area #(.F(F)) u_area (
    .clk, .rst_n,
    .in_valid(dv_valid), .in_ready(dv_ready),
    .frac, .ctl(dv_ctl),
    .out_valid, .out_ready,
    .area(out_inside_area)
  );

`ifndef SYNTHESIS
  a_area_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_inside_area <= ((F+1)'(1) << F))
    else $error("inside area above one");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");
`endif

endmodule
`default_nettype wire
